>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the quaternion unit; clk and rst_n must be in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define QAU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qau: assertion failed");

// next-cycle implication, off during reset
`define QAU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qau: assertion failed");

`endif

>>> rtl/core/qau_pkg.sv
// ---------------------------------------------------------------------------
// qau_pkg
// Shared widths, types and arithmetic helpers of the quaternion unit.
// ---------------------------------------------------------------------------
package qau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  localparam int DW     = DATA_WIDTH;
  localparam int PW     = 2 * DW + 1;          // widest product, DW x (DW+1)
  localparam int RW     = PW - FRAC_BITS + 2;  // rounded product
  localparam int SW     = RW + 2;              // sum of four rounded terms
  localparam int NQ     = 4;
  localparam int NPROD  = NQ * NQ;
  localparam int NROT   = 9;
  localparam int FUNC_W = 3;
  localparam int IN_W   = 8 * DW;
  localparam int OUT_W  = ((4 * DW + 7) / 8) * 8;

  // component positions
  localparam int IX = 0;
  localparam int IY = 1;
  localparam int IZ = 2;
  localparam int IW = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_PROD = 3'd0,
    FN_ROT  = 3'd1,
    FN_CONJ = 3'd2,
    FN_ADD  = 3'd3,
    FN_SUB  = 3'd4,
    FN_DOT  = 3'd5
  } func_t;

  typedef logic signed [DW-1:0] comp_t;
  typedef logic signed [DW:0]   tcomp_t;
  typedef logic signed [RW-1:0] rprod_t;
  typedef logic signed [SW-1:0] sum_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
  } quat_t;

  typedef struct packed {
    logic  flag;
    comp_t val;
  } sat_t;

  typedef struct packed {
    logic   flag;
    tcomp_t val;
  } tsat_t;

  // rounded products of every a and b component pair, index a*NQ+b
  typedef struct packed {
    logic                 valid;
    func_t                func;
    quat_t                a;
    quat_t                b;
    rprod_t [NPROD-1:0]   p;
  } prod_bus_t;

  // combined first level: final values for all but rotation, t for rotation
  typedef struct packed {
    logic   valid;
    func_t  func;
    quat_t  a;
    comp_t  bx;
    comp_t  by;
    comp_t  bz;
    tcomp_t tx;
    tcomp_t ty;
    tcomp_t tz;
    quat_t  r;
    logic   flag;
  } comb_bus_t;

  // control and carried values through the rotation stages
  typedef struct packed {
    logic  valid;
    func_t func;
    comp_t bx;
    comp_t by;
    comp_t bz;
    quat_t r;
    logic  flag;
  } rot_ctl_t;

  localparam sum_t DW_MAX = $signed({{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}});
  localparam sum_t DW_MIN = $signed({{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}});
  localparam sum_t T_MAX  = $signed({{(SW-DW){1'b0}}, {DW{1'b1}}});
  localparam sum_t T_MIN  = $signed({{(SW-DW){1'b1}}, {DW{1'b0}}});

  // round to nearest, ties away from zero, on the magnitude
  function automatic rprod_t round_prod(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [PW-1:0] q;
    rprod_t        s;
    mag = p[PW-1] ? (~p + 1'b1) : p;
    q   = (mag >> FRAC_BITS) + PW'(mag[FRAC_BITS-1]);
    s   = rprod_t'(q[RW-1:0]);
    return p[PW-1] ? -s : s;
  endfunction

  function automatic sum_t ext_r(input rprod_t v);
    return {{(SW-RW){v[RW-1]}}, v};
  endfunction

  function automatic sum_t ext_c(input comp_t v);
    return {{(SW-DW){v[DW-1]}}, v};
  endfunction

  function automatic sat_t sat_dw(input sum_t v);
    sat_t s;
    if (v > DW_MAX) begin
      s.flag = 1'b1;
      s.val  = DW_MAX[DW-1:0];
    end else if (v < DW_MIN) begin
      s.flag = 1'b1;
      s.val  = DW_MIN[DW-1:0];
    end else begin
      s.flag = 1'b0;
      s.val  = v[DW-1:0];
    end
    return s;
  endfunction

  function automatic tsat_t sat_tw(input sum_t v);
    tsat_t s;
    if (v > T_MAX) begin
      s.flag = 1'b1;
      s.val  = T_MAX[DW:0];
    end else if (v < T_MIN) begin
      s.flag = 1'b1;
      s.val  = T_MIN[DW:0];
    end else begin
      s.flag = 1'b0;
      s.val  = v[DW:0];
    end
    return s;
  endfunction

endpackage

>>> rtl/core/qau_prod_stage.sv
// ---------------------------------------------------------------------------
// qau_prod_stage
// Two stages: all sixteen component products, then their rounding.
// ---------------------------------------------------------------------------
module qau_prod_stage
  import qau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_valid,
  input  func_t     in_func,
  input  quat_t     in_a,
  input  quat_t     in_b,
  output prod_bus_t out_bus
);

  logic                     s1_valid_r;
  func_t                    s1_func_r;
  quat_t                    s1_a_r;
  quat_t                    s1_b_r;
  logic signed [2*DW-1:0]   m_r   [NPROD];
  logic signed [2*DW-1:0]   m_nxt [NPROD];
  comp_t                    av    [NQ];
  comp_t                    bv    [NQ];
  prod_bus_t                s2_r;
  prod_bus_t                s2_nxt;

  always_comb begin
    av[IX] = in_a.x;
    av[IY] = in_a.y;
    av[IZ] = in_a.z;
    av[IW] = in_a.w;
    bv[IX] = in_b.x;
    bv[IY] = in_b.y;
    bv[IZ] = in_b.z;
    bv[IW] = in_b.w;
    for (int i = 0; i < NQ; i++) begin
      for (int j = 0; j < NQ; j++) begin
        m_nxt[i*NQ+j] = av[i] * bv[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r <= in_func;
      s1_a_r    <= in_a;
      s1_b_r    <= in_b;
      m_r       <= m_nxt;
    end
  end

  always_comb begin
    s2_nxt.valid = s1_valid_r;
    s2_nxt.func  = s1_func_r;
    s2_nxt.a     = s1_a_r;
    s2_nxt.b     = s1_b_r;
    for (int k = 0; k < NPROD; k++) begin
      s2_nxt.p[k] = round_prod(PW'(m_r[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_bus = s2_r;

endmodule

>>> rtl/core/qau_combine.sv
// ---------------------------------------------------------------------------
// qau_combine
// Sum rounded products into results and the rotation term t, then saturate.
// ---------------------------------------------------------------------------
module qau_combine
  import qau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  prod_bus_t in_bus,
  output comb_bus_t out_bus
);

  sum_t      pe [NQ][NQ];
  sum_t      sx, sy, sz, sw;
  sum_t      tx, ty, tz;
  sat_t      rx, ry, rz, rw;
  tsat_t     ttx, tty, ttz;
  logic      is_rot;
  comb_bus_t c_r;
  comb_bus_t c_nxt;

  always_comb begin
    for (int i = 0; i < NQ; i++) begin
      for (int j = 0; j < NQ; j++) begin
        pe[i][j] = ext_r($signed(in_bus.p[i*NQ+j]));
      end
    end

    // t = 2 * cross(a.xyz, b.xyz)
    tx = (pe[IY][IZ] - pe[IZ][IY]) <<< 1;
    ty = (pe[IZ][IX] - pe[IX][IZ]) <<< 1;
    tz = (pe[IX][IY] - pe[IY][IX]) <<< 1;

    sx = '0;
    sy = '0;
    sz = '0;
    sw = '0;
    unique case (in_bus.func)
      FN_PROD: begin
        sx = pe[IW][IX] + pe[IX][IW] + pe[IY][IZ] - pe[IZ][IY];
        sy = pe[IW][IY] - pe[IX][IZ] + pe[IY][IW] + pe[IZ][IX];
        sz = pe[IW][IZ] + pe[IX][IY] - pe[IY][IX] + pe[IZ][IW];
        sw = pe[IW][IW] - pe[IX][IX] - pe[IY][IY] - pe[IZ][IZ];
      end
      FN_ROT: begin
        sx = '0;
      end
      FN_CONJ: begin
        sx = -ext_c(in_bus.a.x);
        sy = -ext_c(in_bus.a.y);
        sz = -ext_c(in_bus.a.z);
        sw = ext_c(in_bus.a.w);
      end
      FN_ADD: begin
        sx = ext_c(in_bus.a.x) + ext_c(in_bus.b.x);
        sy = ext_c(in_bus.a.y) + ext_c(in_bus.b.y);
        sz = ext_c(in_bus.a.z) + ext_c(in_bus.b.z);
        sw = ext_c(in_bus.a.w) + ext_c(in_bus.b.w);
      end
      FN_SUB: begin
        sx = ext_c(in_bus.a.x) - ext_c(in_bus.b.x);
        sy = ext_c(in_bus.a.y) - ext_c(in_bus.b.y);
        sz = ext_c(in_bus.a.z) - ext_c(in_bus.b.z);
        sw = ext_c(in_bus.a.w) - ext_c(in_bus.b.w);
      end
      FN_DOT: begin
        sw = pe[IX][IX] + pe[IY][IY] + pe[IZ][IZ] + pe[IW][IW];
      end
      default: begin
        sx = '0;
      end
    endcase

    rx     = sat_dw(sx);
    ry     = sat_dw(sy);
    rz     = sat_dw(sz);
    rw     = sat_dw(sw);
    ttx    = sat_tw(tx);
    tty    = sat_tw(ty);
    ttz    = sat_tw(tz);
    is_rot = (in_bus.func == FN_ROT);

    c_nxt.valid = in_bus.valid;
    c_nxt.func  = in_bus.func;
    c_nxt.a     = in_bus.a;
    c_nxt.bx    = in_bus.b.x;
    c_nxt.by    = in_bus.b.y;
    c_nxt.bz    = in_bus.b.z;
    c_nxt.tx    = ttx.val;
    c_nxt.ty    = tty.val;
    c_nxt.tz    = ttz.val;
    c_nxt.r.x   = rx.val;
    c_nxt.r.y   = ry.val;
    c_nxt.r.z   = rz.val;
    c_nxt.r.w   = rw.val;
    c_nxt.flag  = rx.flag | ry.flag | rz.flag | rw.flag
                | (is_rot & (ttx.flag | tty.flag | ttz.flag));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
    end else if (adv) begin
      c_r <= c_nxt;
    end
  end

  assign out_bus = c_r;

endmodule

>>> rtl/core/qau_rot_stage.sv
// ---------------------------------------------------------------------------
// qau_rot_stage
// Rotation second level: a * t products, rounding, final sum and result select.
// ---------------------------------------------------------------------------
module qau_rot_stage
  import qau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  comb_bus_t in_bus,
  output logic      out_valid,
  output quat_t     out_res,
  output logic      out_flag
);

`include "assert_macros.svh"

  rot_ctl_t              s4_r;
  rot_ctl_t              s4_nxt;
  logic signed [PW-1:0]  q4_r   [NROT];
  logic signed [PW-1:0]  q4_nxt [NROT];
  rot_ctl_t              s5_r;
  rprod_t                qr5_r  [NROT];
  rprod_t                qr5_nxt[NROT];
  logic                  out_valid_r;
  func_t                 out_func_r;
  quat_t                 out_res_r;
  logic                  out_flag_r;
  quat_t                 res_nxt;
  logic                  flag_nxt;
  sat_t                  fx, fy, fz;

  // stage 4: nine products of a with t
  always_comb begin
    s4_nxt.valid = in_bus.valid;
    s4_nxt.func  = in_bus.func;
    s4_nxt.bx    = in_bus.bx;
    s4_nxt.by    = in_bus.by;
    s4_nxt.bz    = in_bus.bz;
    s4_nxt.r     = in_bus.r;
    s4_nxt.flag  = in_bus.flag;
    q4_nxt[0] = PW'(in_bus.a.w) * PW'(in_bus.tx);
    q4_nxt[1] = PW'(in_bus.a.y) * PW'(in_bus.tz);
    q4_nxt[2] = PW'(in_bus.a.z) * PW'(in_bus.ty);
    q4_nxt[3] = PW'(in_bus.a.w) * PW'(in_bus.ty);
    q4_nxt[4] = PW'(in_bus.a.z) * PW'(in_bus.tx);
    q4_nxt[5] = PW'(in_bus.a.x) * PW'(in_bus.tz);
    q4_nxt[6] = PW'(in_bus.a.w) * PW'(in_bus.tz);
    q4_nxt[7] = PW'(in_bus.a.x) * PW'(in_bus.ty);
    q4_nxt[8] = PW'(in_bus.a.y) * PW'(in_bus.tx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.valid <= 1'b0;
    end else if (adv) begin
      s4_r <= s4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q4_r <= q4_nxt;
    end
  end

  // stage 5: round
  always_comb begin
    for (int k = 0; k < NROT; k++) begin
      qr5_nxt[k] = round_prod(q4_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_r.valid <= 1'b0;
    end else if (adv) begin
      s5_r <= s4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qr5_r <= qr5_nxt;
    end
  end

  // stage 6: v + w*t + cross(a.xyz, t), or pass the earlier result
  always_comb begin
    fx = sat_dw(ext_c(s5_r.bx) + ext_r(qr5_r[0]) + ext_r(qr5_r[1]) - ext_r(qr5_r[2]));
    fy = sat_dw(ext_c(s5_r.by) + ext_r(qr5_r[3]) + ext_r(qr5_r[4]) - ext_r(qr5_r[5]));
    fz = sat_dw(ext_c(s5_r.bz) + ext_r(qr5_r[6]) + ext_r(qr5_r[7]) - ext_r(qr5_r[8]));
    if (s5_r.func == FN_ROT) begin
      res_nxt.x = fx.val;
      res_nxt.y = fy.val;
      res_nxt.z = fz.val;
      res_nxt.w = '0;
      flag_nxt  = s5_r.flag | fx.flag | fy.flag | fz.flag;
    end else begin
      res_nxt   = s5_r.r;
      flag_nxt  = s5_r.flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s5_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_func_r <= s5_r.func;
      out_res_r  <= res_nxt;
      out_flag_r <= flag_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_flag  = out_flag_r;

  `QAU_ASSERT_IMP(a_rot_w_zero, out_valid_r && out_func_r == FN_ROT, out_res_r.w == '0)
  `QAU_ASSERT_IMP(a_dot_xyz_zero, out_valid_r && out_func_r == FN_DOT, out_res_r.x == '0 && out_res_r.y == '0 && out_res_r.z == '0)
  `QAU_ASSERT_IMP(a_undef_zero, out_valid_r && out_func_r != FN_PROD && out_func_r != FN_ROT && out_func_r != FN_CONJ && out_func_r != FN_ADD && out_func_r != FN_SUB && out_func_r != FN_DOT, out_res_r == '0 && !out_flag_r)
  `QAU_ASSERT_NXT(a_stall_hold, !adv, out_valid_r && $stable(out_res_r) && $stable(out_flag_r))

endmodule

>>> rtl/core/quaternion_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Pipelined fixed-point quaternion ALU with stream input and output.
// ---------------------------------------------------------------------------
// Usage:
//   Input word: in_tdata carries a.x, a.y, a.z, a.w, b.x, b.y, b.z, b.w in
//   signed Q1.14, in_tuser the opcode (product, rotate vector, conjugate,
//   add, subtract, dot). A word is taken when in_tvalid and in_tready are high.
//   Output word: out_tdata carries r.x, r.y, r.z, r.w; out_tuser[0] is set when
//   any component (or a rotation intermediate) was clipped.
//   Pipeline: each accepted word passes six register stages on its way to
//   the output (two of component products and rounding, one combine stage,
//   two of rotation products and rounding, one output register).
//   Every opcode takes the same path.
//   Throughput: one word per cycle unless stalled; the sixteen parallel
//   multipliers of the first level and the nine of the rotation level
//   set the stage depth.
//   Stall: when the output word is held by the receiver, the whole pipeline
//   freezes and in_tready drops; nothing is lost or repeated, and in_tready
//   rises again in the cycle the output is taken.
//   Reset: synchronous, active low; clears all stage valid bits, so the
//   block comes up empty and ready.
// ---------------------------------------------------------------------------
module quaternion_arithmetic_unit
  import qau_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
  input  logic [FUNC_W-1:0] in_tuser,   // func
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // r_x, r_y, r_z, r_w
  output logic [0:0]        out_tuser   // saturated
);

  logic      adv;
  quat_t     in_a;
  quat_t     in_b;
  func_t     in_func;
  prod_bus_t prod_bus;
  comb_bus_t comb_bus;
  quat_t     res;
  logic      res_flag;

  // advance every stage unless the output word is stuck
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // unpack the input word
  assign in_a.x  = in_tdata[0*DW +: DW];
  assign in_a.y  = in_tdata[1*DW +: DW];
  assign in_a.z  = in_tdata[2*DW +: DW];
  assign in_a.w  = in_tdata[3*DW +: DW];
  assign in_b.x  = in_tdata[4*DW +: DW];
  assign in_b.y  = in_tdata[5*DW +: DW];
  assign in_b.z  = in_tdata[6*DW +: DW];
  assign in_b.w  = in_tdata[7*DW +: DW];
  assign in_func = func_t'(in_tuser);

  // stages 1-2: products and rounding
  qau_prod_stage u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .in_func  (in_func),
    .in_a     (in_a),
    .in_b     (in_b),
    .out_bus  (prod_bus)
  );

  // stage 3: sums, saturation, rotation term t
  qau_combine u_comb (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_bus  (prod_bus),
    .out_bus (comb_bus)
  );

  // stages 4-6: rotation level and output register
  qau_rot_stage u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_bus    (comb_bus),
    .out_valid (out_tvalid),
    .out_res   (res),
    .out_flag  (res_flag)
  );

  // pack the output word, zero-fill to whole bytes
  assign out_tdata = OUT_W'({res.w, res.z, res.y, res.x});
  assign out_tuser = res_flag;

endmodule
